/* design/mse_pkg.sv */
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, item kind codes, opcodes and sizes of the MIPS subset executor.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  localparam int unsigned MEM_WORDS = 256;
  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);
  localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW = $clog2(REG_COUNT);

  typedef logic [MEM_AW-1:0] mem_addr_t;
  typedef logic [REG_AW-1:0] reg_addr_t;

  localparam logic [2:0] KIND_EXEC   = 3'd0;
  localparam logic [2:0] KIND_WR_REG = 3'd1;
  localparam logic [2:0] KIND_WR_MEM = 3'd2;
  localparam logic [2:0] KIND_RD_REG = 3'd3;
  localparam logic [2:0] KIND_RD_MEM = 3'd4;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_SLT = 6'h2A;

  typedef struct packed {
    logic        rf_we;
    reg_addr_t   rf_waddr;
    logic [31:0] rf_wdata;
    logic        rf_from_mem;
    logic        mem_we;
    logic        mem_rd_out;
    mem_addr_t   mem_addr;
    logic [31:0] mem_wdata;
    logic [31:0] rv;
    logic        taken;
    logic [15:0] off;
    logic        haz;
    logic        fault;
    logic        dest_upd;
    reg_addr_t   dest_reg;
    logic        dest_valid;
  } exec_res_t;

endpackage

`default_nettype wire

/* design/mips_subset_executor_core.sv */
// ----------------------------------------------------------------------------
// mips_subset_executor_core
// Executes one MIPS subset word or register/memory access per beat.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall) carries one item per beat: an
// instruction to execute, a register or memory preload, or a read back.
// The output channel (out_valid, out_stall) returns exactly one result beat
// per input beat, in order.
// The datapath has three register stages: operand read from the register
// file, execute with data memory read, and the result register. An item
// passes the operand, execute and result registers in turn before its
// result is presented, and one item is taken every cycle unless the output
// stalls; forwarding from the write-back stage keeps back-to-back dependent
// instructions exact. The register file and data memory each have one write
// port, and their registered reads set the stage boundaries.
// Reset clears all stage valid flags, the last destination tracker and the
// per-entry valid bits, so every register and memory word reads as zero.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; no beat is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_executor_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         kind,
  input  wire logic [31:0]        instruction_word,
  input  wire logic [7:0]         target_index,
  input  wire logic signed [31:0] write_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      read_value,
  output logic                    branch_taken,
  output logic signed [15:0]      branch_offset,
  output logic                    hazard_stall,
  output logic                    address_fault
);

  logic                            en;

  logic                            a_valid;
  logic [2:0]                      a_kind;
  logic [31:0]                     a_iw;
  logic [7:0]                      a_idx;
  logic [31:0]                     a_wv;
  mse_pkg::reg_addr_t              a_ra1;
  mse_pkg::reg_addr_t              a_ra2;
  mse_pkg::reg_addr_t              ra1_in;

  logic [31:0]                     rf_q1;
  logic [31:0]                     rf_q2;
  logic [31:0]                     op_a;
  logic [31:0]                     op_b;
  mse_pkg::exec_res_t              a_res;

  logic                            b_valid;
  mse_pkg::exec_res_t              b_res;
  logic [31:0]                     mem_q;
  logic [31:0]                     m_data;
  logic                            b_rf_we;
  logic [31:0]                     b_rf_wdata;
  logic                            b_mem_we;

  logic [mse_pkg::REG_COUNT-1:0]   rf_vld;
  logic [mse_pkg::MEM_WORDS-1:0]   mem_vld;

  logic                            rl_valid;
  mse_pkg::reg_addr_t              rl_addr;
  logic [31:0]                     rl_data;
  logic                            ml_valid;
  mse_pkg::mem_addr_t              ml_addr;
  logic [31:0]                     ml_data;

  mse_pkg::reg_addr_t              last_dest_reg;
  logic                            last_dest_valid;

  logic                            c_valid;
  logic [31:0]                     c_rv;
  logic                            c_taken;
  logic [15:0]                     c_off;
  logic                            c_haz;
  logic                            c_fault;

  function automatic logic [31:0] rf_fwd(
    input mse_pkg::reg_addr_t ra,
    input logic [31:0]        q,
    input logic               wb_we,
    input mse_pkg::reg_addr_t wb_addr,
    input logic [31:0]        wb_data,
    input logic               l_valid,
    input mse_pkg::reg_addr_t l_addr,
    input logic [31:0]        l_data,
    input logic               vld
  );
    logic [31:0] v;
    if (ra == '0) begin
      v = 32'd0;
    end else if (wb_we && (wb_addr == ra)) begin
      v = wb_data;
    end else if (l_valid && (l_addr == ra)) begin
      v = l_data;
    end else if (vld) begin
      v = q;
    end else begin
      v = 32'd0;
    end
    return v;
  endfunction

  assign en        = !c_valid || !out_stall;
  assign in_stall  = !en;
  assign ra1_in    = (kind == mse_pkg::KIND_RD_REG) ? target_index[4:0]
                                                    : instruction_word[25:21];

  assign b_rf_we    = b_valid && b_res.rf_we;
  assign b_mem_we   = b_valid && b_res.mem_we;
  assign b_rf_wdata = b_res.rf_from_mem ? m_data : b_res.rf_wdata;

  assign op_a = rf_fwd(a_ra1, rf_q1, b_rf_we, b_res.rf_waddr, b_rf_wdata,
                       rl_valid, rl_addr, rl_data, rf_vld[a_ra1]);
  assign op_b = rf_fwd(a_ra2, rf_q2, b_rf_we, b_res.rf_waddr, b_rf_wdata,
                       rl_valid, rl_addr, rl_data, rf_vld[a_ra2]);

  always_comb begin
    if (ml_valid && (ml_addr == b_res.mem_addr)) begin
      m_data = ml_data;
    end else if (mem_vld[b_res.mem_addr]) begin
      m_data = mem_q;
    end else begin
      m_data = 32'd0;
    end
  end

  mse_ram #(
    .WIDTH(32),
    .DEPTH(mse_pkg::REG_COUNT)
  ) u_rf_a (
    .clk  (clk),
    .we   (b_rf_we && en),
    .waddr(b_res.rf_waddr),
    .wdata(b_rf_wdata),
    .re   (en),
    .raddr(ra1_in),
    .rdata(rf_q1)
  );

  mse_ram #(
    .WIDTH(32),
    .DEPTH(mse_pkg::REG_COUNT)
  ) u_rf_b (
    .clk  (clk),
    .we   (b_rf_we && en),
    .waddr(b_res.rf_waddr),
    .wdata(b_rf_wdata),
    .re   (en),
    .raddr(instruction_word[20:16]),
    .rdata(rf_q2)
  );

  mse_ram #(
    .WIDTH(32),
    .DEPTH(mse_pkg::MEM_WORDS)
  ) u_dmem (
    .clk  (clk),
    .we   (b_mem_we && en),
    .waddr(b_res.mem_addr),
    .wdata(b_res.mem_wdata),
    .re   (en),
    .raddr(a_res.mem_addr),
    .rdata(mem_q)
  );

  mse_exec u_exec (
    .kind           (a_kind),
    .iw             (a_iw),
    .idx            (a_idx),
    .wv             (a_wv),
    .op_a           (op_a),
    .op_b           (op_b),
    .last_dest_reg  (last_dest_reg),
    .last_dest_valid(last_dest_valid),
    .res            (a_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid         <= 1'b0;
      b_valid         <= 1'b0;
      c_valid         <= 1'b0;
      rf_vld          <= '0;
      mem_vld         <= '0;
      rl_valid        <= 1'b0;
      ml_valid        <= 1'b0;
      last_dest_reg   <= '0;
      last_dest_valid <= 1'b0;
    end else if (en) begin
      a_valid  <= in_valid;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      rl_valid <= b_rf_we;
      ml_valid <= b_mem_we;
      if (b_rf_we) begin
        rf_vld[b_res.rf_waddr] <= 1'b1;
      end
      if (b_mem_we) begin
        mem_vld[b_res.mem_addr] <= 1'b1;
      end
      if (a_valid && a_res.dest_upd) begin
        last_dest_reg   <= a_res.dest_reg;
        last_dest_valid <= a_res.dest_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind  <= kind;
      a_iw    <= instruction_word;
      a_idx   <= target_index;
      a_wv    <= write_value;
      a_ra1   <= ra1_in;
      a_ra2   <= instruction_word[20:16];
      b_res   <= a_res;
      rl_addr <= b_res.rf_waddr;
      rl_data <= b_rf_wdata;
      ml_addr <= b_res.mem_addr;
      ml_data <= b_res.mem_wdata;
      c_rv    <= b_res.mem_rd_out ? m_data : b_res.rv;
      c_taken <= b_res.taken;
      c_off   <= b_res.off;
      c_haz   <= b_res.haz;
      c_fault <= b_res.fault;
    end
  end

  assign out_valid     = c_valid;
  assign read_value    = c_rv;
  assign branch_taken  = c_taken;
  assign branch_offset = c_off;
  assign hazard_stall  = c_haz;
  assign address_fault = c_fault;

endmodule

`default_nettype wire

/* design/mse_ram.sv */
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/mse_exec.sv */
// ----------------------------------------------------------------------------
// mse_exec
// Decodes one item and computes its effects from the resolved source operands.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_exec (
  input  wire logic [2:0]            kind,
  input  wire logic [31:0]           iw,
  input  wire logic [7:0]            idx,
  input  wire logic [31:0]           wv,
  input  wire logic [31:0]           op_a,
  input  wire logic [31:0]           op_b,
  input  wire mse_pkg::reg_addr_t    last_dest_reg,
  input  wire logic                  last_dest_valid,
  output mse_pkg::exec_res_t         res
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [15:0] imm16;
  logic [31:0] imm;
  logic [31:0] sum;
  logic        use_rs;
  logic        use_rt;
  logic        addr_bad;
  logic        idx_reg_ok;
  logic        idx_mem_ok;

  assign op     = iw[31:26];
  assign rs     = iw[25:21];
  assign rt     = iw[20:16];
  assign rd     = iw[15:11];
  assign fn     = iw[5:0];
  assign imm16  = iw[15:0];
  assign imm    = {{16{imm16[15]}}, imm16};
  assign sum    = op_a + imm;
  assign use_rs = last_dest_valid && (rs == last_dest_reg);
  assign use_rt = last_dest_valid && (rt == last_dest_reg);

  assign addr_bad   = sum[31] || ({2'b00, sum[31:2]} >= mse_pkg::MEM_LIMIT);
  assign idx_reg_ok = (idx[7:5] == 3'b000);
  assign idx_mem_ok = ({24'd0, idx} < mse_pkg::MEM_LIMIT);

  always_comb begin
    res = '0;
    res.mem_addr = mse_pkg::mem_addr_t'(sum[31:2]);
    case (kind)
      mse_pkg::KIND_EXEC: begin
        res.dest_upd = 1'b1;
        case (op)
          mse_pkg::OP_RTYPE: begin
            if (fn inside {mse_pkg::FN_ADD, mse_pkg::FN_SUB, mse_pkg::FN_SLT}) begin
              res.haz = use_rs || use_rt;
              res.rf_we = (rd != 5'd0);
              res.rf_waddr = rd;
              if (fn == mse_pkg::FN_ADD) begin
                res.rf_wdata = op_a + op_b;
              end else if (fn == mse_pkg::FN_SUB) begin
                res.rf_wdata = op_a - op_b;
              end else begin
                res.rf_wdata = {31'd0, $signed(op_a) < $signed(op_b)};
              end
              res.dest_reg = rd;
              res.dest_valid = (rd != 5'd0);
            end
          end
          mse_pkg::OP_ADDI: begin
            res.haz = use_rs;
            res.rf_we = (rt != 5'd0);
            res.rf_waddr = rt;
            res.rf_wdata = sum;
            res.dest_reg = rt;
            res.dest_valid = (rt != 5'd0);
          end
          mse_pkg::OP_LW: begin
            res.haz = use_rs;
            res.fault = addr_bad;
            if (!addr_bad) begin
              res.rf_we = (rt != 5'd0);
              res.rf_waddr = rt;
              res.rf_from_mem = 1'b1;
              res.dest_reg = rt;
              res.dest_valid = (rt != 5'd0);
            end
          end
          mse_pkg::OP_SW: begin
            res.haz = use_rs || use_rt;
            res.fault = addr_bad;
            res.mem_we = !addr_bad;
            res.mem_wdata = op_b;
          end
          mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
            res.haz = use_rs || use_rt;
            if ((op == mse_pkg::OP_BEQ) == (op_a == op_b)) begin
              res.taken = 1'b1;
              res.off = imm16;
            end
          end
          default: begin
            res.haz = 1'b0;
          end
        endcase
      end
      mse_pkg::KIND_WR_REG: begin
        res.rf_we = idx_reg_ok && (idx[4:0] != 5'd0);
        res.rf_waddr = idx[4:0];
        res.rf_wdata = wv;
      end
      mse_pkg::KIND_WR_MEM: begin
        res.mem_addr = mse_pkg::mem_addr_t'({24'd0, idx});
        res.mem_we = idx_mem_ok;
        res.mem_wdata = wv;
        res.fault = !idx_mem_ok;
      end
      mse_pkg::KIND_RD_REG: begin
        res.rv = idx_reg_ok ? op_a : 32'd0;
      end
      mse_pkg::KIND_RD_MEM: begin
        res.mem_addr = mse_pkg::mem_addr_t'({24'd0, idx});
        res.mem_rd_out = idx_mem_ok;
        res.fault = !idx_mem_ok;
      end
      default: begin
        res.fault = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the MIPS subset executor core.
// ----------------------------------------------------------------------------
// A queue of beats is filled at time zero: a directed set that covers the
// field extremes, every opcode, hazards, address faults, writes to R0 and
// unused item kinds, followed by random program fragments. Each fragment
// preloads registers, runs instructions and reads state back. A clocked
// driver sends the beats with random gaps. It also holds back at times until
// every pending result has returned. A shadow copy of the register file and
// data memory predicts each result when its beat is accepted. A clocked
// monitor applies random output stalls and compares every result field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;
  import mse_pkg::*;

  localparam int unsigned RANDOM_BEATS = 500;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam reg_addr_t REG_ZERO = 5'd0;
  localparam reg_addr_t BASE_REG = 5'd30;
  localparam logic [5:0] OP_BOGUS = 6'h3F;
  localparam logic [5:0] FN_BOGUS = 6'h3F;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] word;
    logic [7:0]  index;
    logic [31:0] value;
    logic        wait_empty;
    logic [7:0]  gap;
  } beat_t;

  typedef struct packed {
    logic [31:0] rv;
    logic        taken;
    logic [15:0] off;
    logic        haz;
    logic        fault;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [31:0] instruction_word = '0;
  logic [7:0] target_index = '0;
  logic signed [31:0] write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] read_value;
  logic branch_taken;
  logic signed [15:0] branch_offset;
  logic hazard_stall;
  logic address_fault;

  beat_t beat_fifo[$];
  outcome_t outcome_fifo[$];
  beat_t beat_on_bus = '0;

  logic [31:0] shadow_regs[REG_COUNT];
  logic [31:0] shadow_mem[MEM_WORDS];
  reg_addr_t prev_dest = '0;
  logic prev_dest_live = 1'b0;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_wait = 0;
  int unsigned stall_left = 0;
  int unsigned stall_clock = 0;
  int unsigned beats_queued = 0;
  bit sender_calm = 1'b0;
  bit hold_next = 1'b0;

  mips_subset_executor_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .kind             (kind),
    .instruction_word (instruction_word),
    .target_index     (target_index),
    .write_value      (write_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_value       (read_value),
    .branch_taken     (branch_taken),
    .branch_offset    (branch_offset),
    .hazard_stall     (hazard_stall),
    .address_fault    (address_fault)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic depends_on_prev(reg_addr_t r);
    return prev_dest_live && (r == prev_dest);
  endfunction

  function automatic logic [31:0] reg_value(reg_addr_t r);
    return (r == REG_ZERO) ? 32'd0 : shadow_regs[r];
  endfunction

  function automatic void reg_write(reg_addr_t r, logic [31:0] v);
    if (r != REG_ZERO) shadow_regs[r] = v;
  endfunction

  // Predicts the result of one accepted beat and updates the shadow state.
  function automatic outcome_t mips_outcome(beat_t b);
    outcome_t o;
    logic [5:0] op;
    logic [5:0] fn;
    reg_addr_t rs;
    reg_addr_t rt;
    reg_addr_t rd;
    logic [31:0] a;
    logic [31:0] bv;
    logic [31:0] imm;
    logic [31:0] addr;
    reg_addr_t dest;
    logic dest_live;
    o = '0;
    case (b.kind)
      KIND_EXEC: begin
        op = b.word[31:26];
        rs = b.word[25:21];
        rt = b.word[20:16];
        rd = b.word[15:11];
        fn = b.word[5:0];
        imm = {{16{b.word[15]}}, b.word[15:0]};
        a = reg_value(rs);
        bv = reg_value(rt);
        dest = '0;
        dest_live = 1'b0;
        if (op == OP_RTYPE && (fn == FN_ADD || fn == FN_SUB || fn == FN_SLT)) begin
          o.haz = depends_on_prev(rs) || depends_on_prev(rt);
          if (fn == FN_ADD) reg_write(rd, a + bv);
          else if (fn == FN_SUB) reg_write(rd, a - bv);
          else reg_write(rd, ($signed(a) < $signed(bv)) ? 32'd1 : 32'd0);
          dest = rd;
          dest_live = (rd != REG_ZERO);
        end else if (op == OP_ADDI) begin
          o.haz = depends_on_prev(rs);
          reg_write(rt, a + imm);
          dest = rt;
          dest_live = (rt != REG_ZERO);
        end else if (op == OP_LW || op == OP_SW) begin
          addr = a + imm;
          o.haz = (op == OP_LW) ? depends_on_prev(rs)
                                : (depends_on_prev(rs) || depends_on_prev(rt));
          if (addr[31] || (addr >> 2) >= MEM_LIMIT) begin
            o.fault = 1'b1;
          end else if (op == OP_LW) begin
            reg_write(rt, shadow_mem[addr[MEM_AW+1:2]]);
            dest = rt;
            dest_live = (rt != REG_ZERO);
          end else begin
            shadow_mem[addr[MEM_AW+1:2]] = bv;
          end
        end else if (op == OP_BEQ || op == OP_BNE) begin
          o.haz = depends_on_prev(rs) || depends_on_prev(rt);
          if ((op == OP_BEQ) ? (a == bv) : (a != bv)) begin
            o.taken = 1'b1;
            o.off = b.word[15:0];
          end
        end
        prev_dest = dest;
        prev_dest_live = dest_live;
      end
      KIND_WR_REG: begin
        if (32'(b.index) < REG_COUNT) reg_write(b.index[REG_AW-1:0], b.value);
      end
      KIND_WR_MEM: begin
        if (32'(b.index) < MEM_LIMIT) shadow_mem[b.index[MEM_AW-1:0]] = b.value;
        else o.fault = 1'b1;
      end
      KIND_RD_REG: begin
        if (32'(b.index) < REG_COUNT) o.rv = reg_value(b.index[REG_AW-1:0]);
      end
      KIND_RD_MEM: begin
        if (32'(b.index) < MEM_LIMIT) o.rv = shadow_mem[b.index[MEM_AW-1:0]];
        else o.fault = 1'b1;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Most idle runs are short, a few are long.
  function automatic int unsigned idle_run();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic reg_addr_t pick_reg();
    return ($urandom_range(0, 4) == 0) ? reg_addr_t'($urandom_range(0, 31))
                                       : reg_addr_t'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] rtype(logic [5:0] fn, reg_addr_t rs, reg_addr_t rt,
                                        reg_addr_t rd);
    return {OP_RTYPE, rs, rt, rd, 5'($urandom_range(0, 31)), fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, reg_addr_t rs, reg_addr_t rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] random_instruction();
    int unsigned sel;
    reg_addr_t rs;
    reg_addr_t rt;
    reg_addr_t rd;
    logic [15:0] imm;
    logic [5:0] fn;
    int unsigned r;
    sel = $urandom_range(0, 99);
    rs = pick_reg();
    rt = pick_reg();
    rd = pick_reg();
    imm = 16'($urandom());
    if (sel < 30) begin
      case ($urandom_range(0, 2))
        0: fn = FN_ADD;
        1: fn = FN_SUB;
        default: fn = FN_SLT;
      endcase
      return rtype(fn, rs, rt, rd);
    end
    if (sel < 42) return itype(OP_ADDI, rs, rt, imm);
    if (sel < 70) begin
      r = $urandom_range(0, 9);
      if (r < 4) rs = REG_ZERO;
      else if (r < 8) rs = BASE_REG;
      r = $urandom_range(0, 9);
      if (r < 7) imm = 16'($urandom_range(0, 1023));
      else if (r < 9) imm = 16'(-$urandom_range(1, 600));
      return itype((sel < 56) ? OP_LW : OP_SW, rs, rt, imm);
    end
    if (sel < 90) begin
      if ($urandom_range(0, 2) == 0) rt = rs;
      return itype(($urandom_range(0, 1) == 0) ? OP_BEQ : OP_BNE, rs, rt, imm);
    end
    return $urandom();
  endfunction

  task automatic queue_beat(logic [2:0] k, logic [31:0] word, logic [7:0] index,
                            logic [31:0] value);
    beat_t b;
    b.kind = k;
    b.word = word;
    b.index = index;
    b.value = value;
    b.wait_empty = hold_next;
    b.gap = sender_calm ? 8'd0 : 8'(idle_run());
    hold_next = 1'b0;
    beat_fifo.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_exec(logic [31:0] word);
    queue_beat(KIND_EXEC, word, 8'($urandom()), $urandom());
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < REPORT_LIMIT)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Stimulus and end of run.
  initial begin
    for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;

    queue_beat(KIND_WR_REG, $urandom(), 8'd1, 32'h7FFF_FFFF);
    queue_beat(KIND_WR_REG, $urandom(), 8'd2, 32'h8000_0000);
    queue_beat(KIND_WR_REG, $urandom(), 8'd3, 32'hFFFF_FFFF);
    queue_beat(KIND_WR_REG, $urandom(), 8'(REG_ZERO), 32'h0000_1234);
    queue_beat(KIND_WR_REG, $urandom(), 8'd255, 32'h5555_5555);
    queue_beat(KIND_RD_REG, $urandom(), 8'(REG_ZERO), $urandom());
    queue_beat(KIND_RD_REG, $urandom(), 8'd200, $urandom());
    queue_exec(rtype(FN_ADD, 5'd1, 5'd1, 5'd4));
    queue_exec(rtype(FN_SUB, 5'd2, 5'd1, 5'd5));
    queue_exec(rtype(FN_SLT, 5'd2, 5'd1, 5'd6));
    queue_exec(itype(OP_ADDI, REG_ZERO, 5'd9, 16'h7FFF));
    queue_exec(rtype(FN_ADD, 5'd9, 5'd9, 5'd10));
    queue_exec(itype(OP_ADDI, 5'd3, 5'd8, 16'h8000));
    queue_exec(itype(OP_SW, REG_ZERO, 5'd1, 16'h03FC));
    queue_exec(itype(OP_LW, REG_ZERO, 5'd11, 16'h03FC));
    queue_exec(itype(OP_LW, REG_ZERO, 5'd12, 16'hFFFC));
    queue_exec(itype(OP_SW, REG_ZERO, 5'd1, 16'h0400));
    queue_exec(itype(OP_BEQ, REG_ZERO, REG_ZERO, 16'h8000));
    queue_exec(itype(OP_BNE, 5'd1, 5'd2, 16'h7FFF));
    queue_exec(itype(OP_BEQ, 5'd1, 5'd2, 16'h1234));
    queue_exec(32'hFFFF_FFFF);
    queue_exec(rtype(FN_BOGUS, 5'd1, 5'd2, 5'd13));
    hold_next = 1'b1;
    queue_beat(KIND_WR_MEM, $urandom(), 8'd0, 32'h8000_0000);
    queue_beat(KIND_RD_MEM, $urandom(), 8'd0, $urandom());
    queue_beat(KIND_RD_MEM, $urandom(), 8'd255, $urandom());
    queue_exec(itype(OP_BOGUS, 5'd1, 5'd2, 16'h0000));
    for (int k = int'(KIND_RD_MEM) + 1; k < 8; k++)
      queue_beat(3'(k), $urandom(), 8'($urandom()), $urandom());

    beats_queued = 0;
    while (beats_queued < RANDOM_BEATS) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 29) == 0) hold_next = 1'b1;
      repeat ($urandom_range(1, 3))
        queue_beat(KIND_WR_REG, $urandom(), 8'(pick_reg()), pick_value());
      queue_beat(KIND_WR_REG, $urandom(), 8'(BASE_REG), 32'($urandom_range(0, 1100)));
      repeat ($urandom_range(6, 16)) queue_exec(random_instruction());
      repeat ($urandom_range(0, 2))
        queue_beat(KIND_WR_MEM, $urandom(), 8'($urandom()), pick_value());
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1) == 0)
          queue_beat(KIND_RD_REG, $urandom(),
                     ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 40)),
                     $urandom());
        else
          queue_beat(KIND_RD_MEM, $urandom(), 8'($urandom()), $urandom());
      end
      if ($urandom_range(0, 3) == 0)
        queue_beat(3'($urandom_range(0, 7)), $urandom(), 8'($urandom()), $urandom());
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (beat_fifo.size() != 0 || in_valid || outcome_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcome_fifo.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Driver: the bus is free when it is idle or the beat on it was accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) outcome_fifo.push_back(mips_outcome(beat_on_bus));
      if (!in_valid || !in_stall) begin
        if (beat_fifo.size() == 0) begin
          in_valid <= 1'b0;
        end else if (beat_fifo[0].wait_empty && outcome_fifo.size() != 0) begin
          in_valid <= 1'b0;
        end else if (send_wait < beat_fifo[0].gap) begin
          send_wait++;
          in_valid <= 1'b0;
        end else begin
          beat_on_bus = beat_fifo.pop_front();
          send_wait = 0;
          in_valid <= 1'b1;
          kind <= beat_on_bus.kind;
          instruction_word <= beat_on_bus.word;
          target_index <= beat_on_bus.index;
          write_value <= beat_on_bus.value;
        end
      end
    end
  end

  // Monitor: checks each accepted result and applies random stalls.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_fifo.size() == 0) begin
          note_mismatch("unexpected result", 32'd0, 32'(read_value));
        end else begin
          want = outcome_fifo.pop_front();
          if (want.rv !== read_value) note_mismatch("read_value", want.rv, read_value);
          if (want.taken !== branch_taken)
            note_mismatch("branch_taken", 32'(want.taken), 32'(branch_taken));
          if (want.off !== $unsigned(branch_offset))
            note_mismatch("branch_offset", 32'(want.off), 32'($unsigned(branch_offset)));
          if (want.haz !== hazard_stall)
            note_mismatch("hazard_stall", 32'(want.haz), 32'(hazard_stall));
          if (want.fault !== address_fault)
            note_mismatch("address_fault", 32'(want.fault), 32'(address_fault));
        end
      end
      stall_clock++;
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (stall_clock % 300 >= 60) stall_left = idle_run();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
